/* sv/letterbox_nearest_scaler_top_defines.svh */
// assertion macros for the letterbox scaler
`ifndef LETTERBOX_NEAREST_SCALER_TOP_DEFINES_SVH
`define LETTERBOX_NEAREST_SCALER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LBNS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LBNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lbns_pkg.sv */
// shared types and constants of the letterbox scaler
`timescale 1ns / 1ps

package lbns_pkg;

  // frame store
  localparam int unsigned SRC_PIXELS = 131072;
  localparam int unsigned SRC_AW     = $clog2(SRC_PIXELS);
  localparam int unsigned PIX_W      = 24;

  // payload field widths
  localparam int unsigned ADDR_W = 17;
  localparam int unsigned XRGB_W = 32;
  localparam int unsigned BYTE_W = 8;

  // configuration registers
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned SW_W      = 10;
  localparam int unsigned SH_W      = 9;
  localparam int unsigned TGT_W     = 12;

  localparam int unsigned SW_MAX  = 512;
  localparam int unsigned SH_MAX  = 256;
  localparam int unsigned TGT_MAX = 2048;

  localparam int unsigned SW_RST = 320;
  localparam int unsigned SH_RST = 200;
  localparam int unsigned TW_RST = 1280;
  localparam int unsigned TH_RST = 720;

  // raster counters and step accumulators
  localparam int unsigned CNT_W = 11;
  localparam int unsigned QX_W  = 10;
  localparam int unsigned QY_W  = 9;

  // iterative divider
  localparam int unsigned DIV_N_W   = 21;
  localparam int unsigned DIV_D_W   = 12;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);
  localparam int unsigned MUL_W     = 2 * DIV_D_W;

  // command queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_TGT_W = 2'd2,
    REG_TGT_H = 2'd3
  } lbns_reg_e;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EMIT = 1'b1
  } lbns_func_e;

  typedef enum logic [2:0] {
    GEO_DH,
    GEO_DW,
    GEO_ORG,
    GEO_SX,
    GEO_SY,
    GEO_PX,
    GEO_PY,
    GEO_RUN
  } lbns_geo_e;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] load_address;
    logic [XRGB_W-1:0] load_pixel;
  } lbns_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_level;
    logic [BYTE_W-1:0] green_level;
    logic [BYTE_W-1:0] blue_level;
    logic              line_end;
    logic              frame_end;
  } lbns_out_t;

  typedef struct packed {
    lbns_func_e        func;
    logic [SRC_AW-1:0] addr;
    logic [PIX_W-1:0]  rgb;
    logic              black;
    logic              line_end;
    logic              frame_end;
  } lbns_cmd_t;

endpackage

/* sv/lbns_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lbns_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lbns_pkg::DIV_N_W-1:0]  dividend_i,
  input  logic [lbns_pkg::DIV_D_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [lbns_pkg::DIV_N_W-1:0]  quotient_o,
  output logic [lbns_pkg::DIV_D_W-1:0]  remainder_o
);
  import lbns_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_D_W-1:0]   dsr_q, dsr_d;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[DIV_N_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_N_W-2:0], fits};
      rem_d = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* sv/lbns_front.sv */
// front end: registers, geometry pass, raster counters and item classification
`timescale 1ns / 1ps

module lbns_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lbns_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  logic [lbns_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lbns_pkg::lbns_in_t              in_data_i,
  output logic                            push_o,
  output lbns_pkg::lbns_cmd_t             push_cmd_o,
  input  logic                            full_i
);
  import lbns_pkg::*;

  // configuration
  logic [SW_W-1:0]  src_w_q, src_w_d;
  logic [SH_W-1:0]  src_h_q, src_h_d;
  logic [TGT_W-1:0] tgt_w_q, tgt_w_d;
  logic [TGT_W-1:0] tgt_h_q, tgt_h_d;
  logic [SW_W-1:0]  sw;
  logic [SH_W-1:0]  sh;
  logic [TGT_W-1:0] tw;
  logic [TGT_W-1:0] th;

  // geometry
  lbns_geo_e        geo_q, geo_d;
  logic             wait_q, wait_d;
  logic [TGT_W-1:0] dw_q, dw_d;
  logic [TGT_W-1:0] dh_q, dh_d;
  logic [CNT_W-1:0] x0_q, x0_d;
  logic [CNT_W-1:0] y0_q, y0_d;
  logic [TGT_W-1:0] xe_q, xe_d;
  logic [TGT_W-1:0] ye_q, ye_d;
  logic [QX_W-1:0]  sqx_q, sqx_d;
  logic [TGT_W-1:0] srx_q, srx_d;
  logic [QY_W-1:0]  sqy_q, sqy_d;
  logic [TGT_W-1:0] sry_q, sry_d;
  logic [TGT_W-1:0] x0_wide;
  logic [TGT_W-1:0] y0_wide;

  // divider hookup
  logic [DIV_D_W-1:0] mul_a;
  logic [DIV_D_W-1:0] mul_b;
  logic [MUL_W-1:0]   prod;
  logic [DIV_D_W-1:0] div_dsr;
  logic               div_start;
  logic               div_done;
  logic               got;
  logic [DIV_N_W-1:0] div_quo;
  logic [DIV_D_W-1:0] div_rem;
  logic               px_load;
  logic               py_load;

  // raster position and source coordinate accumulators
  logic [CNT_W-1:0]  col_q, col_d;
  logic [CNT_W-1:0]  row_q, row_d;
  logic [QX_W-1:0]   qx_q, qx_d;
  logic [TGT_W-1:0]  rx_q, rx_d;
  logic [QY_W-1:0]   qy_q, qy_d;
  logic [TGT_W-1:0]  ry_q, ry_d;
  logic [TGT_W:0]    rx_sum;
  logic [TGT_W:0]    ry_sum;
  logic [CNT_W-1:0]  col_nxt;
  logic [CNT_W-1:0]  row_nxt;
  logic [TGT_W-1:0]  col_w;
  logic [TGT_W-1:0]  row_w;
  logic              le;
  logic              fe;
  logic              in_pic;
  logic [QY_W+SW_W-1:0] row_base;
  logic [SRC_AW-1:0] pix_idx;
  logic              accept;
  logic              emit;

  // registers taken to their legal ranges
  always_comb begin
    if (src_w_q == '0) sw = SW_W'(1);
    else if (src_w_q > SW_W'(SW_MAX)) sw = SW_W'(SW_MAX);
    else sw = src_w_q;
    if (src_h_q == '0) sh = SH_W'(1);
    else if (src_h_q > SH_W'(SH_MAX)) sh = SH_W'(SH_MAX);
    else sh = src_h_q;
    if (tgt_w_q == '0) tw = TGT_W'(1);
    else if (tgt_w_q > TGT_W'(TGT_MAX)) tw = TGT_W'(TGT_MAX);
    else tw = tgt_w_q;
    if (tgt_h_q == '0) th = TGT_W'(1);
    else if (tgt_h_q > TGT_W'(TGT_MAX)) th = TGT_W'(TGT_MAX);
    else th = tgt_h_q;
  end

  assign prod = MUL_W'(mul_a) * MUL_W'(mul_b);
  assign got  = wait_q && div_done;

  lbns_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (prod[DIV_N_W-1:0]),
    .divisor_i   (div_dsr),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign x0_wide = (tw - dw_q) >> 1;
  assign y0_wide = (th - dh_q) >> 1;

  // geometry sequencer: picture size, origin, steps, then current position
  always_comb begin
    geo_d     = geo_q;
    wait_d    = wait_q;
    dw_d      = dw_q;
    dh_d      = dh_q;
    x0_d      = x0_q;
    y0_d      = y0_q;
    xe_d      = xe_q;
    ye_d      = ye_q;
    sqx_d     = sqx_q;
    srx_d     = srx_q;
    sqy_d     = sqy_q;
    sry_d     = sry_q;
    src_w_d   = src_w_q;
    src_h_d   = src_h_q;
    tgt_w_d   = tgt_w_q;
    tgt_h_d   = tgt_h_q;
    mul_a     = '0;
    mul_b     = '0;
    div_dsr   = '0;
    div_start = 1'b0;
    px_load   = 1'b0;
    py_load   = 1'b0;

    if (geo_q != GEO_ORG && geo_q != GEO_RUN) begin
      if (!wait_q) begin
        div_start = 1'b1;
        wait_d    = 1'b1;
      end else if (div_done) begin
        wait_d = 1'b0;
      end
    end

    unique case (geo_q)
      GEO_DH: begin
        mul_a   = tw;
        mul_b   = DIV_D_W'(sh);
        div_dsr = DIV_D_W'(sw);
        if (got) begin
          if (div_quo > DIV_N_W'(th)) begin
            dh_d  = th;
            geo_d = GEO_DW;
          end else begin
            dh_d  = div_quo[TGT_W-1:0];
            dw_d  = tw;
            geo_d = GEO_ORG;
          end
        end
      end
      GEO_DW: begin
        mul_a   = th;
        mul_b   = DIV_D_W'(sw);
        div_dsr = DIV_D_W'(sh);
        if (got) begin
          dw_d  = div_quo[TGT_W-1:0];
          geo_d = GEO_ORG;
        end
      end
      GEO_ORG: begin
        x0_d  = x0_wide[CNT_W-1:0];
        y0_d  = y0_wide[CNT_W-1:0];
        xe_d  = x0_wide + dw_q;
        ye_d  = y0_wide + dh_q;
        geo_d = GEO_SX;
      end
      GEO_SX: begin
        mul_a   = DIV_D_W'(sw);
        mul_b   = DIV_D_W'(1);
        div_dsr = dw_q;
        if (got) begin
          sqx_d = div_quo[QX_W-1:0];
          srx_d = div_rem;
          geo_d = GEO_SY;
        end
      end
      GEO_SY: begin
        mul_a   = DIV_D_W'(sh);
        mul_b   = DIV_D_W'(1);
        div_dsr = dh_q;
        if (got) begin
          sqy_d = div_quo[QY_W-1:0];
          sry_d = div_rem;
          geo_d = GEO_PX;
        end
      end
      GEO_PX: begin
        // offset into the picture; meaningless outside it, reloaded at the left edge
        mul_a   = DIV_D_W'(col_q - x0_q);
        mul_b   = DIV_D_W'(sw);
        div_dsr = dw_q;
        if (got) begin
          px_load = 1'b1;
          geo_d   = GEO_PY;
        end
      end
      GEO_PY: begin
        mul_a   = DIV_D_W'(row_q - y0_q);
        mul_b   = DIV_D_W'(sh);
        div_dsr = dh_q;
        if (got) begin
          py_load = 1'b1;
          geo_d   = GEO_RUN;
        end
      end
      GEO_RUN: begin
        geo_d = GEO_RUN;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SRC_W: src_w_d = cfg_data_i[SW_W-1:0];
        REG_SRC_H: src_h_d = cfg_data_i[SH_W-1:0];
        REG_TGT_W: tgt_w_d = cfg_data_i[TGT_W-1:0];
        REG_TGT_H: tgt_h_d = cfg_data_i[TGT_W-1:0];
      endcase
      geo_d  = GEO_DH;
      wait_d = 1'b0;
    end
  end

  // input side
  assign in_stall_o = !(geo_q == GEO_RUN && !full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign emit       = accept && (in_data_i.func == FUNC_EMIT);

  assign col_w  = TGT_W'(col_q);
  assign row_w  = TGT_W'(row_q);
  assign le     = (col_w + TGT_W'(1)) >= tw;
  assign fe     = le && ((row_w + TGT_W'(1)) >= th);
  assign in_pic = (col_q >= x0_q) && (col_w < xe_q) && (row_q >= y0_q) && (row_w < ye_q);

  assign row_base = (QY_W+SW_W)'(qy_q) * (QY_W+SW_W)'(sw);
  assign pix_idx  = SRC_AW'(row_base + (QY_W+SW_W)'(qx_q));

  assign col_nxt = le ? '0 : col_q + CNT_W'(1);
  assign row_nxt = le ? (fe ? '0 : row_q + CNT_W'(1)) : row_q;

  assign rx_sum = (TGT_W+1)'(rx_q) + (TGT_W+1)'(srx_q);
  assign ry_sum = (TGT_W+1)'(ry_q) + (TGT_W+1)'(sry_q);

  // source coordinates follow the raster by step plus carry
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    qx_d  = qx_q;
    rx_d  = rx_q;
    qy_d  = qy_q;
    ry_d  = ry_q;
    if (px_load) begin
      qx_d = div_quo[QX_W-1:0];
      rx_d = div_rem;
    end
    if (py_load) begin
      qy_d = div_quo[QY_W-1:0];
      ry_d = div_rem;
    end
    if (emit) begin
      col_d = col_nxt;
      row_d = row_nxt;
      if (col_nxt == x0_q) begin
        qx_d = '0;
        rx_d = '0;
      end else if (rx_sum >= (TGT_W+1)'(dw_q)) begin
        qx_d = qx_q + sqx_q + QX_W'(1);
        rx_d = TGT_W'(rx_sum - (TGT_W+1)'(dw_q));
      end else begin
        qx_d = qx_q + sqx_q;
        rx_d = rx_sum[TGT_W-1:0];
      end
      if (le) begin
        if (row_nxt == y0_q) begin
          qy_d = '0;
          ry_d = '0;
        end else if (ry_sum >= (TGT_W+1)'(dh_q)) begin
          qy_d = qy_q + sqy_q + QY_W'(1);
          ry_d = TGT_W'(ry_sum - (TGT_W+1)'(dh_q));
        end else begin
          qy_d = qy_q + sqy_q;
          ry_d = ry_sum[TGT_W-1:0];
        end
      end
    end
  end

  always_comb begin
    push_cmd_o.func      = lbns_func_e'(in_data_i.func);
    push_cmd_o.addr      = (in_data_i.func == FUNC_EMIT) ? pix_idx
                                                         : SRC_AW'(in_data_i.load_address);
    push_cmd_o.rgb       = in_data_i.load_pixel[PIX_W-1:0];
    push_cmd_o.black     = !in_pic;
    push_cmd_o.line_end  = le;
    push_cmd_o.frame_end = fe;
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_q   <= GEO_DH;
      wait_q  <= 1'b0;
      src_w_q <= SW_W'(SW_RST);
      src_h_q <= SH_W'(SH_RST);
      tgt_w_q <= TGT_W'(TW_RST);
      tgt_h_q <= TGT_W'(TH_RST);
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      geo_q   <= geo_d;
      wait_q  <= wait_d;
      src_w_q <= src_w_d;
      src_h_q <= src_h_d;
      tgt_w_q <= tgt_w_d;
      tgt_h_q <= tgt_h_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dw_q  <= dw_d;
    dh_q  <= dh_d;
    x0_q  <= x0_d;
    y0_q  <= y0_d;
    xe_q  <= xe_d;
    ye_q  <= ye_d;
    sqx_q <= sqx_d;
    srx_q <= srx_d;
    sqy_q <= sqy_d;
    sry_q <= sry_d;
    qx_q  <= qx_d;
    rx_q  <= rx_d;
    qy_q  <= qy_d;
    ry_q  <= ry_d;
  end

endmodule

/* sv/lbns_fifo.sv */
// short command queue between front and back end
`timescale 1ns / 1ps

module lbns_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lbns_pkg::lbns_cmd_t  push_cmd_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output lbns_pkg::lbns_cmd_t  head_o,
  output logic                 empty_o
);
  import lbns_pkg::*;

  lbns_cmd_t           entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) wr_ptr_d = wr_ptr_q + QUEUE_AW'(1);
    if (pop_i) rd_ptr_d = rd_ptr_q + QUEUE_AW'(1);
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + (QUEUE_AW+1)'(1);
      2'b01:   cnt_d = cnt_q - (QUEUE_AW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

/* sv/lbns_back.sv */
// back end: frame store access and registered output beat
`timescale 1ns / 1ps

module lbns_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  lbns_pkg::lbns_cmd_t  head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lbns_pkg::lbns_out_t  out_data_o
);
  import lbns_pkg::*;

  logic [PIX_W-1:0] frame_store_q [SRC_PIXELS];
  logic [PIX_W-1:0] rdata_q;
  logic             st_we;
  logic             st_re;

  logic      s1_valid_q, s1_valid_d;
  logic      s1_black_q, s1_le_q, s1_fe_q;
  logic      s1_move;
  logic      out_valid_q, out_valid_d;
  lbns_out_t out_q, out_d;

  // read stage moves on when the output register is free or being taken
  assign s1_move = s1_valid_q && (!out_valid_q || !out_stall_i);
  // loads never wait for the output side
  assign pop_o   = !empty_i && (head_i.func == FUNC_LOAD || !s1_valid_q || s1_move);
  assign st_we   = pop_o && (head_i.func == FUNC_LOAD);
  assign st_re   = pop_o && (head_i.func == FUNC_EMIT);

  always_ff @(posedge clk_i) begin
    if (st_we) frame_store_q[head_i.addr] <= head_i.rgb;
    if (st_re) rdata_q <= frame_store_q[head_i.addr];
  end

  assign s1_valid_d  = st_re || (s1_valid_q && !s1_move);
  assign out_valid_d = s1_move || (out_valid_q && out_stall_i);

  always_comb begin
    out_d = out_q;
    if (s1_move) begin
      out_d.red_level   = s1_black_q ? '0 : rdata_q[3*BYTE_W-1:2*BYTE_W];
      out_d.green_level = s1_black_q ? '0 : rdata_q[2*BYTE_W-1:BYTE_W];
      out_d.blue_level  = s1_black_q ? '0 : rdata_q[BYTE_W-1:0];
      out_d.line_end    = s1_le_q;
      out_d.frame_end   = s1_fe_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_re) begin
      s1_black_q <= head_i.black;
      s1_le_q    <= head_i.line_end;
      s1_fe_q    <= head_i.frame_end;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/letterbox_nearest_scaler_top.sv */
// top level of the letterboxing nearest-neighbour scaler
// Input beats carry func, load_address and load_pixel. A load beat writes one
// RGB pixel into the frame store and gives no output; an emit beat gives the
// next pixel of the output raster, black outside the centred picture, with
// line_end and frame_end flags. Both channels use valid/stall handshakes.
// Throughput: one beat per cycle while in_stall_o is low, load or emit, mixed
// freely. The configuration port writes one of four size registers per cycle
// and must be used only with the block idle; the block never checks it. After
// reset and after every register write, in_stall_o stays high for a geometry
// pass: five or six 21-bit divisions on the shared one-bit-per-cycle divider
// (picture size, per-pixel steps, and the source coordinates of the current
// raster position). The frame store needs no clearing; reading an unwritten
// pixel gives junk. When the receiver stalls, the output beat holds, the read
// stage and a four-entry queue fill, and then in_stall_o rises; loads keep
// draining.
`timescale 1ns / 1ps
`include "letterbox_nearest_scaler_top_defines.svh"

module letterbox_nearest_scaler_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lbns_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  logic [lbns_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lbns_pkg::lbns_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lbns_pkg::lbns_out_t             out_data_o
);
  import lbns_pkg::*;

  logic      push;
  lbns_cmd_t push_cmd;
  logic      q_full;
  logic      pop;
  lbns_cmd_t head;
  logic      q_empty;

  lbns_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .full_i      (q_full)
  );

  lbns_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty)
  );

  lbns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `LBNS_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push, !q_full, "queue written while full")
  `LBNS_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop, !q_empty, "queue read while empty")
  `LBNS_ASSERT_NEXT(a_cfg_restalls, clk_i, rst_ni, cfg_we_i, in_stall_o, "no geometry pass after write")

endmodule

/* tb/letterbox_nearest_scaler_top_test.sv */
// self-checking testbench for the letterbox nearest-neighbour scaler
`timescale 1ns / 1ps

module letterbox_nearest_scaler_top_test;
  import lbns_pkg::*;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  lbns_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  lbns_out_t            out_data_o;

  // shadow of the scaler state
  logic [PIX_W-1:0] pic_store [SRC_PIXELS];
  logic [CNT_W-1:0] ras_col   = '0;
  logic [CNT_W-1:0] ras_row   = '0;
  logic [SW_W-1:0]  src_w_reg = SW_W'(SW_RST);
  logic [SH_W-1:0]  src_h_reg = SH_W'(SH_RST);
  logic [TGT_W-1:0] tgt_w_reg = TGT_W'(TW_RST);
  logic [TGT_W-1:0] tgt_h_reg = TGT_W'(TH_RST);

  lbns_in_t    pixel_jobs[$];
  lbns_out_t   pixel_expect[$];
  int unsigned store_filled = 0;
  int unsigned live_pixels  = 1;
  int          mismatches   = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          src_gap      = 0;
  int          snk_gap      = 0;
  bit          calm         = 1'b0;
  bit          beat_taken   = 1'b0;

  letterbox_nearest_scaler_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned fit_range(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one accepted input beat: store a pixel, or work out the next raster pixel
  function automatic void scale_beat(input lbns_in_t beat);
    int unsigned sw, sh, tw, th, dw, dh, x0, y0, sx, sy, idx;
    logic [PIX_W-1:0] rgb;
    logic last_col, last_row;
    lbns_out_t px;
    if (beat.func == FUNC_LOAD) begin
      pic_store[beat.load_address] = beat.load_pixel[PIX_W-1:0];
      return;
    end
    sw = fit_range(src_w_reg, 1, SW_MAX);
    sh = fit_range(src_h_reg, 1, SH_MAX);
    tw = fit_range(tgt_w_reg, 1, TGT_MAX);
    th = fit_range(tgt_h_reg, 1, TGT_MAX);
    dw = tw;
    dh = sh * tw / sw;
    if (dh > th) begin
      dh = th;
      dw = sw * th / sh;
    end
    x0 = (tw - dw) / 2;
    y0 = (th - dh) / 2;
    rgb = '0;
    if (dw != 0 && dh != 0 && ras_col >= x0 && ras_row >= y0 &&
        ras_col - x0 < dw && ras_row - y0 < dh) begin
      sy  = (ras_row - y0) * sh / dh;
      sx  = (ras_col - x0) * sw / dw;
      idx = sy * sw + sx;
      if (idx < SRC_PIXELS) rgb = pic_store[idx];
    end
    // a counter past a shrunk target counts as the last one
    last_col = (ras_col + 1 >= tw);
    last_row = (ras_row + 1 >= th);
    px.red_level   = rgb[23:16];
    px.green_level = rgb[15:8];
    px.blue_level  = rgb[7:0];
    px.line_end    = last_col;
    px.frame_end   = last_col && last_row;
    pixel_expect.push_back(px);
    if (last_col) begin
      ras_col = '0;
      ras_row = last_row ? '0 : ras_row + 1'b1;
    end else begin
      ras_col = ras_col + 1'b1;
    end
  endfunction

  function automatic void check_field(string field, logic [BYTE_W-1:0] want,
                                      logic [BYTE_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  // input acceptance feeds the shadow; output beats are checked in order
  always @(posedge clk_i) begin
    lbns_out_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      scale_beat(in_data_i);
      beat_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_expect.size() == 0) begin
        mismatches++;
        $display("%0t: output beat with nothing expected, expected none, got %p",
                 $time, out_data_o);
      end else begin
        want = pixel_expect.pop_front();
        check_field("red_level", want.red_level, out_data_o.red_level);
        check_field("green_level", want.green_level, out_data_o.green_level);
        check_field("blue_level", want.blue_level, out_data_o.blue_level);
        check_field("line_end", BYTE_W'(want.line_end), BYTE_W'(out_data_o.line_end));
        check_field("frame_end", BYTE_W'(want.frame_end), BYTE_W'(out_data_o.frame_end));
      end
    end
  end

  always @(negedge clk_i) begin
    logic     next_valid;
    lbns_in_t next_beat;
    next_valid = in_valid_i;
    next_beat  = in_data_i;
    if (beat_taken) begin
      beat_taken = 1'b0;
      next_valid = 1'b0;
    end
    if (!next_valid && rst_ni) begin
      if (src_gap > 0) begin
        src_gap--;
      end else if (pixel_jobs.size() != 0) begin
        if (!calm && $urandom_range(99) < src_idle_pct) begin
          src_gap = $urandom_range(0, 4);
        end else begin
          next_beat  = pixel_jobs.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    in_valid_i <= next_valid;
    in_data_i  <= next_beat;
  end

  always @(negedge clk_i) begin
    if (snk_gap > 0) begin
      snk_gap--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(99) < snk_idle_pct) begin
      snk_gap = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic queue_load(int unsigned addr, logic [XRGB_W-1:0] pixel);
    lbns_in_t beat;
    beat.func         = FUNC_LOAD;
    beat.load_address = addr[ADDR_W-1:0];
    beat.load_pixel   = pixel;
    pixel_jobs.push_back(beat);
  endtask

  task automatic queue_emit();
    lbns_in_t beat;
    beat.func         = FUNC_EMIT;
    beat.load_address = ADDR_W'($urandom_range(0, SRC_PIXELS - 1));
    beat.load_pixel   = $urandom();
    pixel_jobs.push_back(beat);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pixel_jobs.size() != 0 || in_valid_i || pixel_expect.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(lbns_reg_e idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      REG_SRC_W: src_w_reg = value[SW_W-1:0];
      REG_SRC_H: src_h_reg = value[SH_W-1:0];
      REG_TGT_W: tgt_w_reg = value[TGT_W-1:0];
      REG_TGT_H: tgt_h_reg = value[TGT_W-1:0];
    endcase
  endtask

  // new sizes with the block idle, then fill every source pixel the picture can read
  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned tw,
                              int unsigned th);
    drain();
    // a load may still be in the pipe after the last result
    repeat (8) @(posedge clk_i);
    write_reg(REG_SRC_W, CFG_W'(sw));
    write_reg(REG_SRC_H, CFG_W'(sh));
    write_reg(REG_TGT_W, CFG_W'(tw));
    write_reg(REG_TGT_H, CFG_W'(th));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    live_pixels = fit_range(src_w_reg, 1, SW_MAX) * fit_range(src_h_reg, 1, SH_MAX);
    while (store_filled < live_pixels) begin
      queue_load(store_filled, $urandom());
      store_filled++;
    end
    case ($urandom_range(2))
      0: src_idle_pct = 0;
      1: src_idle_pct = 10;
      default: src_idle_pct = 35;
    endcase
    case ($urandom_range(2))
      0: snk_idle_pct = 0;
      1: snk_idle_pct = 10;
      default: snk_idle_pct = 35;
    endcase
  endtask

  task automatic random_geometry();
    int unsigned sw, sh, tw, th;
    case ($urandom_range(9))
      0: begin
        sw = $urandom_range(1) ? SW_MAX : $urandom_range(400, 1023);
        sh = $urandom_range(0, 1);
      end
      1: begin
        sh = $urandom_range(1) ? SH_MAX : $urandom_range(200, 511);
        sw = $urandom_range(0, 2);
      end
      default: begin
        sw = $urandom_range(0, 24);
        sh = $urandom_range(0, 24);
      end
    endcase
    case ($urandom_range(9))
      0: begin
        tw = $urandom_range(0, 4095);
        th = $urandom_range(0, 4095);
      end
      1: begin
        tw = $urandom_range(1) ? 0 : TGT_MAX;
        th = $urandom_range(1) ? 4095 : 1;
      end
      2: begin
        tw = $urandom_range(1, 40);
        th = $urandom_range(1, 40);
      end
      default: begin
        tw = $urandom_range(1, 12);
        th = $urandom_range(1, 12);
      end
    endcase
    set_geometry(sw, sh, tw, th);
  endtask

  // mostly emits over a filled picture, loads redraw it or land anywhere
  task automatic run_mix(int n, int emit_pct, int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      if ($urandom_range(99) < emit_pct)
        queue_emit();
      else if ($urandom_range(1))
        queue_load($urandom_range(0, live_pixels - 1), $urandom());
      else
        queue_load($urandom_range(0, SRC_PIXELS - 1), $urandom());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // field extremes, then emits in the left border of the reset raster
    queue_load(17'h00000, 32'hFFFF_FFFF);
    queue_load(17'h1FFFF, 32'h0000_0000);
    queue_load(17'h0AAAA, 32'h55AA_55AA);
    queue_load(17'h15555, 32'hAA55_AA55);
    repeat (12) queue_emit();

    // registers out of range, saturated at use
    set_geometry(1023, 0, 4095, 0);
    run_mix(40, 90, 20);
    // picture height rounds to nothing, and the column is past the new width
    set_geometry(512, 1, 20, 2048);
    run_mix(30, 90, -1);
    set_geometry(1, 511, 8, 4095);
    run_mix(40, 80, -1);
    set_geometry(3, 2, 2048, 2048);
    run_mix(30, 80, -1);
    // picture width rounds to nothing
    set_geometry(1, 256, 30, 100);
    run_mix(30, 90, -1);

    repeat (11) begin
      random_geometry();
      run_mix($urandom_range(20, 35), 75,
              $urandom_range(1) ? int'($urandom_range(5, 20)) : -1);
    end

    calm = 1'b1;
    random_geometry();
    run_mix(100, 75, -1);

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
